### src/ttt_pkg.sv
// Shared types and constants of the timeout table timer.
package ttt_pkg;

    localparam int TIME_W      = 64;
    localparam int SMP_W       = 32;
    localparam int ID_W        = 16;
    localparam int SEL_W       = 4;
    localparam int OP_W        = 3;
    localparam int KIND_W      = 3;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int IV_W        = 31;
    localparam int GAP_W       = 33;
    localparam int MAX_EXPIRED = 16;
    localparam int EXP_CNT_W   = 5;

    localparam logic [CFG_W-1:0] TICK_INTERVAL_RST = 31'd100000;
    localparam logic [CFG_W-1:0] MIN_LEAD_RST      = 31'd1000;

    localparam logic [OP_W-1:0] OP_INIT        = 3'd0;
    localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_TIME   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUBSCRIBED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TIME       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MISMATCH   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKWARDS_GUARD = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SMP_W-1:0]  count_sample;
        logic [ID_W-1:0]   waiter_id;
        logic [TIME_W-1:0] timeout_len;
        logic [SEL_W-1:0]  slot_sel;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   out_waiter;
        logic [SEL_W-1:0]  out_slot;
        logic [TIME_W-1:0] time_value;
        logic [SMP_W-1:0]  compare_value;
        logic              went_backwards;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] length;
    } t_slot_entry;

    typedef struct packed {
        logic wr;
        logic set_used;
        logic clr_used;
    } t_slot_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SUB_SCAN,
        S_UNSUB_CHK,
        S_CMP_CHK,
        S_CMP_DIV,
        S_CMP_ADJ,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT
    } t_state;

endpackage

### src/ttt_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
interface ttt_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/ttt_remainder.sv
// Bit-serial restoring remainder unit for the compare catch-up step.
module ttt_remainder
    import ttt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [GAP_W-1:0] i_dividend,
    input  logic [IV_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic [IV_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(GAP_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [GAP_W-1:0] r_dvd;
    logic [IV_W-1:0]  r_div;
    logic [IV_W-1:0]  r_rem;
    logic [IV_W:0]    shifted;
    logic [IV_W:0]    trial;
    logic             fits;

    // Partial remainder stays below the divisor, so one extra bit is enough.
    assign shifted = {r_rem, r_dvd[GAP_W-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign trial   = fits ? (shifted - {1'b0, r_div}) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(GAP_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[GAP_W-2:0], 1'b0};
            r_rem <= trial[IV_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

### src/ttt_slot_mem.sv
// Waiter table: owner/start/length memory plus per-slot used flags.
module ttt_slot_mem
    import ttt_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_slot_cmd   i_cmd,
    input  logic [IW-1:0] i_waddr,
    input  t_slot_entry i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_slot_entry o_rdata,
    output logic [SLOTS-1:0] o_used
);

    t_slot_entry      mem [SLOTS];
    t_slot_entry      r_rdata;
    logic [SLOTS-1:0] r_used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.set_used) begin
            r_used[i_waddr] <= 1'b1;
        end else if (i_cmd.clr_used) begin
            r_used[i_waddr] <= 1'b0;
        end
    end

    assign o_rdata = r_rdata;
    assign o_used  = r_used;

endmodule

### src/timeout_table_timer_unit.sv
// Top level: 64-bit time extension, waiter timeout table and compare stepping.
//
//  channel  dir  payload   request carries
//  i_req    in   t_item    op, count sample, waiter, timeout length, slot
//  o_rsp    out  t_result  kind, waiter, slot, time, compare, backwards, last
//  i_cfg_*  in   31 bit    register write, index 0..2
//
// Each request passes decode before its result goes to the output register: init,
// read time, unused ops and a refused unsubscribe go straight to emit, a checked
// unsubscribe first checks the slot owner; subscribe walks the used flags.
// Tick steps the compare value, then scans the table, reading each used slot;
// the compare value catches up when it must (33-step remainder unit).
// Reset loads the config reset values and clears time, compare and the used flags.
// A stalled output holds the sequencer; no new request is taken until the
// last result of the current one sits in the output register.
module timeout_table_timer_unit
    import ttt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ttt_stream_if.sink           i_req,
    ttt_stream_if.source         o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOT_END = CW'(SLOTS);
    localparam logic [EXP_CNT_W-1:0] EXP_END = EXP_CNT_W'(MAX_EXPIRED);

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_tick_interval;
    logic [CFG_W-1:0]     r_min_lead;
    logic                 r_backwards_guard;
    logic [TIME_W-1:0]    r_wide_time;
    logic [SMP_W-1:0]     r_last_cmp;

    t_item                r_item;
    logic [TIME_W-1:0]    r_now;
    logic                 r_back;
    logic [SMP_W-1:0]     r_cmp;
    logic [GAP_W-1:0]     r_gap;
    logic [CW-1:0]        r_idx;
    logic [EXP_CNT_W-1:0] r_nexp;
    t_result              r_pend;
    t_result              r_out;
    logic                 r_ovalid;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    t_result              out_data;

    logic [TIME_W-1:0]    ext_now;
    logic                 ext_back;
    logic [SMP_W-1:0]     drop;
    logic [IV_W-1:0]      iv;
    logic [SMP_W-1:0]     diff;
    logic                 lead_lt;
    logic [GAP_W-1:0]     gap;
    logic [IV_W-1:0]      rem;
    logic [IV_W-1:0]      pad;
    logic [SMP_W-1:0]     cmp_sum;
    logic                 div_busy;
    logic                 div_start;

    logic [SLOTS-1:0]     used;
    t_slot_entry          rd_entry;
    t_slot_entry          wr_entry;
    t_slot_cmd            slot_cmd;
    logic [IW-1:0]        waddr;
    logic [IW-1:0]        raddr;
    logic [IW-1:0]        sel_idx;
    logic [IW-1:0]        cur_idx;
    logic                 sel_ok;
    logic                 sel_used;
    logic                 cur_used;
    logic                 scan_end;
    logic                 owner_match;
    logic [TIME_W-1:0]    waited;
    logic                 expired;

    function automatic t_result make_result(
        input logic [KIND_W-1:0] kind,
        input logic [ID_W-1:0]   waiter,
        input logic [SEL_W-1:0]  slot,
        input logic [TIME_W-1:0] tv,
        input logic [SMP_W-1:0]  cmp,
        input logic              back,
        input logic              last
    );
        t_result res;
        res.kind           = kind;
        res.out_waiter     = waiter;
        res.out_slot       = slot;
        res.time_value     = tv;
        res.compare_value  = cmp;
        res.went_backwards = back;
        res.last           = last;
        return res;
    endfunction

    // ---------------- datapath helpers ----------------
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // Extend the sample against the stored time: wrap forward or hold.
    always_comb begin
        drop     = r_wide_time[SMP_W-1:0] - r_item.count_sample;
        ext_now  = {r_wide_time[TIME_W-1:SMP_W], r_item.count_sample};
        ext_back = 1'b0;
        if (r_item.count_sample < r_wide_time[SMP_W-1:0]) begin
            if (!drop[SMP_W-1]) begin
                ext_now  = r_wide_time;
                ext_back = 1'b1;
            end else begin
                ext_now = {r_wide_time[TIME_W-1:SMP_W] + 32'd1, r_item.count_sample};
            end
        end
    end

    assign iv      = (r_tick_interval == '0) ? IV_W'(1) : r_tick_interval;
    assign diff    = r_cmp - r_item.count_sample;
    assign lead_lt = $signed({diff[SMP_W-1], diff}) < $signed({2'b00, r_min_lead});
    assign gap     = {2'b00, r_min_lead} - {diff[SMP_W-1], diff};
    assign pad     = iv - rem;
    // Round the gap up to a whole number of intervals: gap + (iv - gap mod iv).
    assign cmp_sum = r_cmp + r_gap[SMP_W-1:0] + ((rem != '0) ? SMP_W'(pad) : '0);

    assign sel_idx  = IW'(r_item.slot_sel);
    assign cur_idx  = r_idx[IW-1:0];
    assign sel_ok   = 7'(r_item.slot_sel) < 7'(SLOTS);
    assign sel_used = sel_ok && used[sel_idx];
    assign scan_end = r_idx == SLOT_END;
    assign cur_used = !scan_end && used[cur_idx];

    assign owner_match = rd_entry.owner == r_item.waiter_id;
    assign waited      = r_now - rd_entry.start;
    assign expired     = !(r_backwards_guard && waited[TIME_W-1])
                         && (waited > rd_entry.length);

    assign wr_entry.owner  = r_item.waiter_id;
    assign wr_entry.start  = r_now;
    assign wr_entry.length = r_item.timeout_len;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_item.op)
                    OP_SUBSCRIBE:   n_state = S_SUB_SCAN;
                    OP_UNSUBSCRIBE: n_state = sel_used ? S_UNSUB_CHK : S_EMIT;
                    OP_TICK:        n_state = S_CMP_CHK;
                    default:        n_state = S_EMIT;
                endcase
            end
            S_SUB_SCAN: begin
                if (scan_end || !used[cur_idx]) n_state = S_EMIT;
            end
            S_UNSUB_CHK: n_state = S_EMIT;
            S_CMP_CHK:   n_state = lead_lt ? S_CMP_DIV : S_SCAN_RD;
            S_CMP_DIV: begin
                if (!div_busy) n_state = S_CMP_ADJ;
            end
            S_CMP_ADJ:   n_state = S_SCAN_RD;
            S_SCAN_RD: begin
                if (scan_end || r_nexp == EXP_END) n_state = S_EMIT;
                else if (cur_used)                 n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!expired || out_free) n_state = S_SCAN_RD;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        slot_cmd  = '0;
        waddr     = cur_idx;
        raddr     = cur_idx;
        div_start = 1'b0;
        out_load  = 1'b0;
        out_data  = r_pend;
        case (r_state)
            S_DECODE: raddr = sel_idx;
            S_SUB_SCAN: begin
                if (!scan_end && !used[cur_idx]) begin
                    slot_cmd.wr       = 1'b1;
                    slot_cmd.set_used = 1'b1;
                end
            end
            S_UNSUB_CHK: begin
                waddr             = sel_idx;
                slot_cmd.clr_used = owner_match;
            end
            S_CMP_CHK: div_start = lead_lt;
            S_SCAN_CHK: begin
                out_load = expired && out_free;
                out_data = make_result(KIND_EXPIRED, rd_entry.owner, SEL_W'(r_idx),
                                       r_now, r_cmp, r_back, 1'b0);
            end
            S_EMIT: out_load = out_free;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_ovalid          <= 1'b0;
            r_tick_interval   <= TICK_INTERVAL_RST;
            r_min_lead        <= MIN_LEAD_RST;
            r_backwards_guard <= 1'b0;
            r_wide_time       <= '0;
            r_last_cmp        <= '0;
        end else begin
            r_state <= n_state;
            if (out_load)         r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK_INTERVAL:   r_tick_interval   <= i_cfg_data;
                    CFG_MIN_LEAD:        r_min_lead        <= i_cfg_data;
                    CFG_BACKWARDS_GUARD: r_backwards_guard <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_state == S_DECODE && r_item.op == OP_INIT) begin
                r_wide_time <= {32'd0, r_item.count_sample};
                r_last_cmp  <= r_item.count_sample + {1'b0, r_tick_interval};
            end else if (r_state == S_DECODE && r_item.op == OP_TICK) begin
                r_wide_time <= ext_now;
            end else if (r_state == S_CMP_CHK && !lead_lt) begin
                r_last_cmp <= r_cmp;
            end else if (r_state == S_CMP_ADJ) begin
                r_last_cmp <= cmp_sum;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= out_data;
        case (r_state)
            S_IDLE: begin
                if (accept) r_item <= i_req.payload;
            end
            S_DECODE: begin
                r_now  <= ext_now;
                r_back <= ext_back;
                r_idx  <= '0;
                r_nexp <= '0;
                r_cmp  <= r_last_cmp + SMP_W'(iv);
                case (r_item.op)
                    OP_INIT: r_pend <= make_result(KIND_ACK, '0, '0,
                        {32'd0, r_item.count_sample},
                        r_item.count_sample + {1'b0, r_tick_interval}, 1'b0, 1'b1);
                    OP_UNSUBSCRIBE: r_pend <= make_result(KIND_MISMATCH, '0, '0,
                        r_wide_time, '0, 1'b0, 1'b1);
                    OP_READ_TIME: r_pend <= make_result(KIND_TIME, '0, '0,
                        ext_now, '0, ext_back, 1'b1);
                    OP_SUBSCRIBE, OP_TICK: ;
                    default: r_pend <= make_result(KIND_ACK, '0, '0,
                        r_wide_time, '0, 1'b0, 1'b1);
                endcase
            end
            S_SUB_SCAN: begin
                if (scan_end) begin
                    r_pend <= make_result(KIND_FULL, r_item.waiter_id, '0,
                                          r_now, '0, r_back, 1'b1);
                end else if (!used[cur_idx]) begin
                    r_pend <= make_result(KIND_SUBSCRIBED, r_item.waiter_id,
                                          SEL_W'(r_idx), r_now, '0, r_back, 1'b1);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_UNSUB_CHK: begin
                r_pend <= make_result(owner_match ? KIND_ACK : KIND_MISMATCH, '0, '0,
                                      r_wide_time, '0, 1'b0, 1'b1);
            end
            S_CMP_CHK: r_gap <= gap;
            S_CMP_ADJ: r_cmp <= cmp_sum;
            S_SCAN_RD: begin
                if (scan_end || r_nexp == EXP_END) begin
                    r_pend <= make_result(KIND_TICK_DONE, '0, '0,
                                          r_now, r_cmp, r_back, 1'b1);
                end else if (!cur_used) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_SCAN_CHK: begin
                if (!expired) begin
                    r_idx <= r_idx + CW'(1);
                end else if (out_free) begin
                    r_idx  <= r_idx + CW'(1);
                    r_nexp <= r_nexp + EXP_CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- submodules ----------------
    ttt_remainder u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gap),
        .i_divisor  (iv),
        .o_busy     (div_busy),
        .o_rem      (rem)
    );

    ttt_slot_mem #(.SLOTS(SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (slot_cmd),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_raddr (raddr),
        .o_rdata (rd_entry),
        .o_used  (used)
    );

    // ---------------- ports ----------------
    assign i_req.ready   = r_state == S_IDLE;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    // ---------------- checks ----------------
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !div_busy)
        else $error("request taken while remainder unit busy");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_check_used_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> cur_used)
        else $error("expiry check on a free slot");

    a_expiry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.kind == KIND_EXPIRED) |-> !o_rsp.payload.last)
        else $error("expiry marked as final result");

    a_expiry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD || r_state == S_SCAN_CHK) |-> (r_nexp <= EXP_END))
        else $error("expiry count beyond limit");

endmodule
